### rtl/led_blink_pattern_sequencer_defines.svh
// Assertion helpers for the pattern sequencer
`ifndef LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH
`define LED_BLINK_PATTERN_SEQUENCER_DEFINES_SVH

// Checks a property on every clock edge outside reset
`define LBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included
`define LBPS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/lbps_pkg.sv
`default_nettype none
package lbps_pkg;
  localparam int PatternDepth = 256;
  localparam int RingSlots = 8;
  localparam logic [9:0] TickMsReset = 10'd10;

  localparam logic [2:0] CmdTick = 3'd0;
  localparam logic [2:0] CmdWrite = 3'd1;
  localparam logic [2:0] CmdStart = 3'd2;
  localparam logic [2:0] CmdStartNow = 3'd3;
  localparam logic [2:0] CmdStop = 3'd4;

  localparam logic [2:0] KindOn = 3'd0;
  localparam logic [2:0] KindOff = 3'd1;
  localparam logic [2:0] KindRepeat = 3'd2;
  localparam logic [2:0] KindRepeatStart = 3'd3;
  localparam logic [2:0] KindLoop = 3'd4;
  localparam logic [2:0] KindStop = 3'd5;
endpackage
`default_nettype wire

### rtl/led_blink_pattern_sequencer.sv
// Sequential player: one transaction at a time, in_ready low until its result is taken.
// A write goes straight to its result. A tick checks the step duration; when play starts or
// a step is taken it reads the repeat-start, repeat, loop/stop and drive entries in turn, and
// a stop entry walks the ring (1 slot/cycle). Start and stop search the ring for the slot.
// Synchronous active-high reset clears control state and sets tick_ms to 10;
// pattern memory and slot links are undefined until written.
`default_nettype none
`include "led_blink_pattern_sequencer_defines.svh"
module led_blink_pattern_sequencer #(
  parameter int PATTERN_DEPTH = lbps_pkg::PatternDepth,
  parameter int RING_SLOTS = lbps_pkg::RingSlots
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [9:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [7:0]  entry_addr,
  input  wire logic [2:0]  entry_kind,
  input  wire logic [15:0] entry_value,
  input  wire logic [7:0]  pattern_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             led_on,
  output logic             playing,
  output logic [3:0]       active_count,
  output logic             ring_full
);
  localparam int AW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CW = $clog2(RING_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_FREE, S_LINK, S_UNLINK, S_RD, S_EVAL, S_DONE
  } state_t;

  // what to do once a find finishes
  typedef enum logic [1:0] {
    F_START, F_STOP, F_TICKSTOP
  } find_t;

  logic [2:0]  kind_mem [PATTERN_DEPTH];
  logic [15:0] value_mem [PATTERN_DEPTH];
  logic [7:0]  slot_pattern [RING_SLOTS];
  logic [SW-1:0] slot_next [RING_SLOTS];
  logic [SW-1:0] slot_prev [RING_SLOTS];
  logic [RING_SLOTS-1:0] slot_used;

  state_t state;
  find_t  fmode;
  logic [9:0]  tick_ms;
  logic [2:0]  cmd_q;
  logic [7:0]  paddr;
  logic        head_valid, cur_valid;
  logic [SW-1:0] head_slot, cur_slot, node, found;
  logic [CW-1:0] iter;
  logic        play_active, led_level, full;
  logic [7:0]  play_base, step_index, repeat_start;
  logic [15:0] elapsed_ms, repeat_done;
  logic [2:0]  rd_kind;
  logic [15:0] rd_value;
  logic [1:0]  phase;    // 0 repeat-start, 1 repeat, 2 loop/stop, 3 drive
  logic        wr_en;
  logic [CW-1:0] count;

  logic [AW-1:0] rd_addr;
  logic [16:0] e_sum;
  logic [15:0] e_sat;
  logic [7:0]  step_inc;
  assign rd_addr = AW'(play_base + step_index);
  assign e_sum = {1'b0, elapsed_ms} + {7'd0, tick_ms};
  assign e_sat = e_sum[16] ? 16'hFFFF : e_sum[15:0];
  assign step_inc = step_index + 8'd1;

  always_comb begin
    count = '0;
    for (int i = 0; i < RING_SLOTS; i++) count = count + CW'(slot_used[i]);
  end

  assign cfg_ready = (state == S_IDLE);
  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);
  assign led_on = led_level;
  assign playing = play_active;
  assign active_count = 4'(count);
  assign ring_full = full;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kind_mem[AW'(entry_addr)] <= entry_kind;
      value_mem[AW'(entry_addr)] <= entry_value;
    end
    rd_kind <= kind_mem[rd_addr];
    rd_value <= value_mem[rd_addr];
  end

  assign wr_en = in_valid && in_ready && (cmd == lbps_pkg::CmdWrite);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fmode <= F_START;
      tick_ms <= lbps_pkg::TickMsReset;
      slot_used <= '0;
      head_valid <= 1'b0;
      cur_valid <= 1'b0;
      head_slot <= '0;
      cur_slot <= '0;
      play_active <= 1'b0;
      play_base <= '0;
      step_index <= '0;
      elapsed_ms <= '0;
      repeat_start <= '0;
      repeat_done <= '0;
      led_level <= 1'b0;
      full <= 1'b0;
      phase <= '0;
      iter <= '0;
      node <= '0;
      found <= '0;
      cmd_q <= '0;
      paddr <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) tick_ms <= cfg_data;
          if (in_valid) begin
            cmd_q <= cmd;
            paddr <= pattern_addr;
            full <= 1'b0;
            // free-slot search starts at slot 0 when the ring is empty
            node <= head_valid ? head_slot : '0;
            case (cmd)
              lbps_pkg::CmdTick: begin
                fmode <= F_TICKSTOP;
                phase <= 2'd0;
                if (play_active) begin
                  // iter[0] low: duration check still to do
                  elapsed_ms <= e_sat;
                  iter <= '0;
                  state <= S_RD;
                end else if (cur_valid) begin
                  play_base <= slot_pattern[cur_slot];
                  play_active <= 1'b1;
                  repeat_done <= '0;
                  repeat_start <= '0;
                  elapsed_ms <= '0;
                  step_index <= '0;
                  iter <= CW'(1);
                  state <= S_RD;
                end else begin
                  iter <= '0;
                  state <= S_DONE;
                end
              end
              lbps_pkg::CmdStart, lbps_pkg::CmdStartNow: begin
                fmode <= F_START;
                iter <= '0;
                state <= head_valid ? S_FIND : S_FREE;
              end
              lbps_pkg::CmdStop: begin
                fmode <= F_STOP;
                iter <= '0;
                state <= head_valid ? S_FIND : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_FIND: begin
          if (slot_pattern[node] == paddr) begin
            found <= node;
            if (fmode == F_START) begin
              cur_slot <= node;
              cur_valid <= 1'b1;
              if (cmd_q == lbps_pkg::CmdStartNow) play_active <= 1'b0;
              state <= S_DONE;
            end else begin
              state <= S_UNLINK;
            end
          end else if (slot_next[node] == head_slot ||
                       iter == CW'(RING_SLOTS - 1)) begin
            iter <= '0;
            node <= '0;
            case (fmode)
              F_START: state <= S_FREE;
              F_TICKSTOP: begin
                fmode <= F_STOP;  // nothing removed
                state <= S_EVAL;
              end
              default: state <= S_DONE;
            endcase
          end else begin
            node <= slot_next[node];
            iter <= iter + 1'b1;
          end
        end
        S_FREE: begin
          if (!slot_used[node]) begin
            state <= S_LINK;
          end else if (iter == CW'(RING_SLOTS - 1)) begin
            full <= 1'b1;
            if (cmd_q == lbps_pkg::CmdStartNow) play_active <= 1'b0;
            state <= S_DONE;
          end else begin
            node <= SW'(node + 1'b1);
            iter <= iter + 1'b1;
          end
        end
        S_LINK: begin
          slot_used[node] <= 1'b1;
          slot_pattern[node] <= paddr;
          if (head_valid) begin
            slot_next[node] <= head_slot;
            slot_prev[node] <= slot_prev[head_slot];
            slot_next[slot_prev[head_slot]] <= node;
            slot_prev[head_slot] <= node;
          end else begin
            slot_next[node] <= node;
            slot_prev[node] <= node;
          end
          head_slot <= node;
          head_valid <= 1'b1;
          cur_slot <= node;
          cur_valid <= 1'b1;
          if (cmd_q == lbps_pkg::CmdStartNow) play_active <= 1'b0;
          state <= S_DONE;
        end
        S_UNLINK: begin
          slot_next[slot_prev[found]] <= slot_next[found];
          slot_prev[slot_next[found]] <= slot_prev[found];
          if (head_slot == found) begin
            if (slot_next[found] == found) head_valid <= 1'b0;
            else head_slot <= slot_next[found];
          end
          if (cur_valid && cur_slot == found) begin
            if (slot_next[found] == found) cur_valid <= 1'b0;
            else cur_slot <= slot_next[found];
          end
          slot_used[found] <= 1'b0;
          if (fmode == F_TICKSTOP) begin
            fmode <= F_STOP;
            state <= S_EVAL;
          end else begin
            state <= S_DONE;
          end
        end
        S_RD: state <= S_EVAL;  // memory read latency
        S_EVAL: begin
          if (fmode == F_STOP && cmd_q == lbps_pkg::CmdTick) begin
            // resume after a tick-stop
            fmode <= F_START;
            if (!cur_valid) begin
              play_active <= 1'b0;
              state <= S_DONE;
            end else begin
              play_base <= slot_pattern[cur_slot];
              step_index <= '0;
              phase <= 2'd3;
              state <= S_RD;
            end
          end else if (cmd_q == lbps_pkg::CmdTick && fmode == F_TICKSTOP &&
                       phase == 2'd0 && !iter[0]) begin
            iter[0] <= 1'b1;
            if (elapsed_ms >= rd_value) begin
              step_index <= step_inc;
              elapsed_ms <= '0;
              state <= S_RD;
            end else begin
              state <= S_DONE;
            end
          end else begin
            case (phase)
              2'd0: begin
                if (rd_kind == lbps_pkg::KindRepeatStart) begin
                  step_index <= step_inc;
                  repeat_start <= step_inc;
                  repeat_done <= '0;
                end
                phase <= 2'd1;
                state <= S_RD;
              end
              2'd1: begin
                if (rd_kind == lbps_pkg::KindRepeat) begin
                  if (((repeat_done == 16'hFFFF) ? repeat_done : repeat_done + 16'd1)
                      >= rd_value) begin
                    repeat_done <= '0;
                    repeat_start <= '0;
                    step_index <= step_inc;
                  end else begin
                    repeat_done <= (repeat_done == 16'hFFFF) ? repeat_done
                                                             : repeat_done + 16'd1;
                    elapsed_ms <= '0;
                    step_index <= repeat_start;
                  end
                end
                phase <= 2'd2;
                state <= S_RD;
              end
              2'd2: begin
                phase <= 2'd3;
                if (rd_kind == lbps_pkg::KindLoop) begin
                  if (!cur_valid) begin
                    play_active <= 1'b0;
                    state <= S_DONE;
                  end else begin
                    cur_slot <= slot_next[cur_slot];
                    play_base <= slot_pattern[slot_next[cur_slot]];
                    step_index <= '0;
                    state <= S_RD;
                  end
                end else if (rd_kind == lbps_pkg::KindStop) begin
                  paddr <= play_base;
                  node <= head_slot;
                  iter <= '0;
                  if (head_valid) state <= S_FIND;
                  else begin
                    fmode <= F_STOP;
                    state <= S_EVAL;
                  end
                end else begin
                  state <= S_RD;
                end
              end
              default: begin
                if (rd_kind == lbps_pkg::KindOn) led_level <= 1'b1;
                else if (rd_kind == lbps_pkg::KindOff) led_level <= 1'b0;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LBPS_ASSERT(a_not_both, !(in_ready && out_valid), "ready while result pending")
  `LBPS_ASSERT(a_count, count <= CW'(RING_SLOTS), "ring count out of range")
  `LBPS_ASSERT(a_head, (count == '0) |-> !head_valid, "head with empty ring")
  `LBPS_ASSERT(a_hold, (out_valid && !out_ready) |=> out_valid, "result dropped")
endmodule
`default_nettype wire
